// ===== rtl/per_track_threat_escalation_core_defines.svh =====
// ---------------------------------------------------------------------------
// Threat escalation core assertion macros
// Shared concurrent assertion wrappers; ASSERT_OFF compiles them out.
// ---------------------------------------------------------------------------
`ifndef PER_TRACK_THREAT_ESCALATION_CORE_DEFINES_SVH
`define PER_TRACK_THREAT_ESCALATION_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every rising clock edge outside reset
`define PTTE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition must never be seen outside reset
`define PTTE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define PTTE_ASSERT(lbl, clk, rstn, prop, msg)
`define PTTE_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== rtl/ptte_pkg.sv =====
// ---------------------------------------------------------------------------
// Threat escalation package
// Word types, table entry type, codes and timing constants of the core.
// ---------------------------------------------------------------------------
package ptte_pkg;

    localparam int PTTE_TABLE_DEPTH = 64;

    // item kinds
    localparam logic [1:0] KIND_CLASSIFY = 2'd0;
    localparam logic [1:0] KIND_PRUNE    = 2'd1;
    localparam logic [1:0] KIND_KEEP     = 2'd2;
    localparam logic [1:0] KIND_SWEEP    = 2'd3;

    // escalation states
    localparam logic [2:0] ESC_UNKNOWN     = 3'd0;
    localparam logic [2:0] ESC_TRACKED     = 3'd1;
    localparam logic [2:0] ESC_IDENTIFIED  = 3'd2;
    localparam logic [2:0] ESC_THREATENING = 3'd3;
    localparam logic [2:0] ESC_ENGAGED     = 3'd4;

    // threat levels
    localparam logic [1:0] LVL_UNKNOWN = 2'd0;
    localparam logic [1:0] LVL_BENIGN  = 2'd1;
    localparam logic [1:0] LVL_SUSPECT = 2'd2;
    localparam logic [1:0] LVL_THREAT  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_THREAT_RANGE = 2'd0;
    localparam logic [1:0] CFG_THREAT_SPEED = 2'd1;
    localparam logic [1:0] CFG_DWELL_LIMIT  = 2'd2;
    localparam logic [1:0] CFG_STALE_TMO    = 2'd3;

    localparam logic [22:0] RST_THREAT_RANGE = 23'd100000;
    localparam logic [14:0] RST_THREAT_SPEED = 15'd500;
    localparam logic [31:0] RST_DWELL_LIMIT  = 32'd1000;
    localparam logic [31:0] RST_STALE_TMO    = 32'd5000;

    // fixed rule limits
    localparam logic signed [40:0] IDENT_HOLD_MS    = 41'sd500;
    localparam logic signed [40:0] ENGAGE_HOLD_MS   = 41'sd2000;
    localparam logic signed [40:0] QUALITY_DWELL_MS = 41'sd3000;
    localparam logic signed [15:0] BENIGN_SPEED_CMS = 16'sd200;
    localparam logic [47:0]        ENGAGE_RANGE_SQ  = 48'd40000;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        track_id;
        logic [39:0]        now_ms;
        logic signed [7:0]  class_code;
        logic signed [15:0] speed_cms;
        logic signed [15:0] doppler_cms;
        logic signed [23:0] pos_x_cm;
        logic signed [23:0] pos_y_cm;
        logic [9:0]         confidence;
        logic               confirmed;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  threat_grade;
        logic [2:0]  escalation;
        logic [31:0] dwell_ms;
        logic [3:0]  quality_tenths;
        logic        table_full;
        logic [6:0]  removed_count;
    } t_out_word;

    typedef struct packed {
        logic [31:0] track;
        logic [2:0]  esc;
        logic [39:0] first_seen;
        logic [39:0] last_seen;
        logic [39:0] ident_at;
        logic [39:0] threat_at;
        logic        ident_set;
        logic        threat_set;
    } t_entry;

    typedef struct packed {
        logic [14:0] threat_speed;
        logic [31:0] dwell_limit;
    } t_rule_cfg;

    // signed difference of two 40-bit timestamps
    function automatic logic signed [40:0] tdiff(input logic [39:0] a, input logic [39:0] b);
        tdiff = $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

endpackage

// ===== rtl/ptte_rules.sv =====
// ---------------------------------------------------------------------------
// Threat escalation rules
// Grades one report and takes at most one escalation step on the selected entry.
// ---------------------------------------------------------------------------
module ptte_rules (
    input  ptte_pkg::t_in_word  i_in,
    input  ptte_pkg::t_entry    i_ent,
    input  ptte_pkg::t_rule_cfg i_cfg,
    input  logic [46:0]         i_px2,
    input  logic [46:0]         i_py2,
    input  logic [45:0]         i_lim2,
    output ptte_pkg::t_entry    o_ent,
    output logic [1:0]          o_level,
    output logic [31:0]         o_dwell_ms,
    output logic [3:0]          o_quality
);
    import ptte_pkg::*;

    logic signed [40:0] w_dwell;
    logic signed [40:0] w_dwell_lim;
    logic [47:0]        w_r2;
    logic               w_in_range;
    logic               w_closing;
    logic signed [16:0] w_dop;
    logic signed [16:0] w_neg_spd;
    logic [39:0]        w_ident_at;
    logic [39:0]        w_threat_at;
    logic [3:0]         w_q;

    assign w_dwell     = tdiff(i_in.now_ms, i_ent.first_seen);
    assign w_dwell_lim = $signed({9'b0, i_cfg.dwell_limit});
    assign w_r2        = {1'b0, i_px2} + {1'b0, i_py2};
    assign w_in_range  = w_r2 < {2'b0, i_lim2};
    assign w_dop       = 17'(i_in.doppler_cms);
    assign w_neg_spd   = $signed(17'd0 - {2'b0, i_cfg.threat_speed});
    assign w_closing   = w_dop < w_neg_spd;
    assign w_ident_at  = i_ent.ident_set ? i_ent.ident_at : i_in.now_ms;
    assign w_threat_at = i_ent.threat_set ? i_ent.threat_at : i_in.now_ms;

    // grade the report
    always_comb begin
        if (i_in.class_code < 8'sd0) begin
            o_level = LVL_UNKNOWN;
        end else if (i_in.class_code == 8'sd0) begin
            o_level = (i_in.speed_cms <= BENIGN_SPEED_CMS && i_in.speed_cms >= -BENIGN_SPEED_CMS)
                      ? LVL_BENIGN : LVL_SUSPECT;
        end else begin
            o_level = i_in.confidence[9] ? LVL_THREAT : LVL_UNKNOWN;
        end
    end

    // take at most one escalation step
    always_comb begin
        o_ent           = i_ent;
        o_ent.last_seen = i_in.now_ms;
        unique case (i_ent.esc)
            ESC_UNKNOWN: begin
                if (w_dwell > w_dwell_lim) o_ent.esc = ESC_TRACKED;
            end
            ESC_TRACKED: begin
                if (i_in.class_code == 8'sd0) begin
                    o_ent.ident_set = 1'b1;
                    o_ent.ident_at  = w_ident_at;
                    if (tdiff(i_in.now_ms, w_ident_at) > IDENT_HOLD_MS) begin
                        o_ent.esc = ESC_IDENTIFIED;
                    end
                end
            end
            ESC_IDENTIFIED: begin
                if (w_in_range && w_closing) begin
                    o_ent.threat_set = 1'b1;
                    o_ent.threat_at  = w_threat_at;
                    if (tdiff(i_in.now_ms, w_threat_at) > w_dwell_lim) begin
                        o_ent.esc       = ESC_THREATENING;
                        o_ent.threat_at = i_in.now_ms;
                    end
                end else begin
                    o_ent.threat_set = 1'b0;
                    o_ent.threat_at  = '0;
                end
            end
            ESC_THREATENING: begin
                if (w_r2 < ENGAGE_RANGE_SQ &&
                    tdiff(i_in.now_ms, i_ent.threat_at) > ENGAGE_HOLD_MS) begin
                    o_ent.esc = ESC_ENGAGED;
                end
            end
            default: begin
                // engaged holds
            end
        endcase
    end

    // score quality and saturate dwell
    always_comb begin
        w_q = 4'd3;
        if (i_in.class_code >= 8'sd0) w_q = w_q + 4'd3;
        if (i_in.confirmed)           w_q = w_q + 4'd2;
        if (w_dwell > QUALITY_DWELL_MS) w_q = w_q + 4'd2;
        o_quality = w_q;
        if (w_dwell[40]) begin
            o_dwell_ms = '0;
        end else if (w_dwell[39:32] != 8'd0) begin
            o_dwell_ms = '1;
        end else begin
            o_dwell_ms = w_dwell[31:0];
        end
    end

endmodule

// ===== rtl/per_track_threat_escalation_core.sv =====
// ---------------------------------------------------------------------------
// Per-track threat escalation core
// Track table with escalation state, pruning and keep/sweep housekeeping.
// ---------------------------------------------------------------------------
// The table, 64 entries deep by default, lives in one memory with a single
// registered read port, and each item walks all entries through it, one a
// cycle, to find the lowest matching slot, the lowest free slot or the
// entries to drop; a multiply stage and an update stage follow. One item is
// worked at a time; a finished result waits in the output register while the
// next item is taken in. The table starts empty after reset with no clearing
// pass.
`include "per_track_threat_escalation_core_defines.svh"

module per_track_threat_escalation_core #(
    parameter int TABLE_DEPTH = ptte_pkg::PTTE_TABLE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ptte_pkg::t_in_word  i_data,
    output logic                o_stall,
    output logic                o_valid,
    output ptte_pkg::t_out_word o_data,
    input  logic                i_stall,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);
    import ptte_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_CALC  = 4'b0100,
        S_APPLY = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [22:0] r_cfg_range;
    logic [14:0] r_cfg_speed;
    logic [31:0] r_cfg_dwell;
    logic [31:0] r_cfg_stale;

    t_in_word r_in;
    t_entry   mem [TABLE_DEPTH];
    t_entry   r_rd;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [TABLE_DEPTH-1:0] r_keep;

    logic [AW-1:0] r_rd_addr;
    logic          r_issuing;
    logic [AW-1:0] r_chk_idx;
    logic          r_chk_vld;

    logic          r_found;
    logic [AW-1:0] r_slot;
    t_entry        r_match;
    logic          r_free_found;
    logic [AW-1:0] r_free;
    logic [6:0]    r_removed;

    t_entry      r_cur;
    logic [AW-1:0] r_cur_slot;
    logic        r_full;
    logic [46:0] r_px2;
    logic [46:0] r_py2;
    logic [45:0] r_lim2;

    logic        r_out_vld;
    t_out_word   r_out;

    logic signed [47:0] w_px_sq;
    logic signed [47:0] w_py_sq;
    logic [45:0]        w_lim_sq;
    logic               w_out_free;
    logic               w_accept;
    logic               w_scan_end;
    logic               w_mem_we;
    t_entry             w_new_ent;
    t_rule_cfg          w_rule_cfg;
    t_entry             w_upd_ent;
    logic [1:0]         w_level;
    logic [31:0]        w_dwell_ms;
    logic [3:0]         w_quality;
    t_out_word          w_word;

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_vld;
    assign o_data     = r_out;
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_vld || !i_stall;
    assign w_scan_end = r_chk_vld && (r_chk_idx == LAST_IDX);
    assign w_mem_we   = (r_state == S_APPLY) && w_out_free &&
                        (r_in.kind == KIND_CLASSIFY) && !r_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_range <= RST_THREAT_RANGE;
            r_cfg_speed <= RST_THREAT_SPEED;
            r_cfg_dwell <= RST_DWELL_LIMIT;
            r_cfg_stale <= RST_STALE_TMO;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THREAT_RANGE: r_cfg_range <= i_cfg_data[22:0];
                CFG_THREAT_SPEED: r_cfg_speed <= i_cfg_data[14:0];
                CFG_DWELL_LIMIT:  r_cfg_dwell <= i_cfg_data;
                CFG_STALE_TMO:    r_cfg_stale <= i_cfg_data;
                default: begin end
            endcase
        end
    end

    // sequence the item
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_SCAN;
            S_SCAN:  if (w_scan_end) n_state = S_CALC;
            S_CALC:  n_state = S_APPLY;
            S_APPLY: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // table memory: one read and one write port; the write of one item lands
    // before the next item's walk starts, so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[r_cur_slot] <= w_upd_ent;
        end
        r_rd <= mem[r_rd_addr];
    end

    // walk the table one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing <= 1'b0;
            r_chk_vld <= 1'b0;
        end else if (w_accept) begin
            r_issuing <= 1'b1;
            r_chk_vld <= 1'b0;
        end else begin
            r_chk_vld <= r_issuing;
            if (r_issuing && r_rd_addr == LAST_IDX) r_issuing <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in      <= i_data;
            r_rd_addr <= '0;
        end else if (r_issuing) begin
            r_rd_addr <= r_rd_addr + AW'(1);
        end
        r_chk_idx <= r_rd_addr;
    end

    // match, free slot and drop bookkeeping, plus the per-entry flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_keep  <= '0;
        end else begin
            if (w_accept) begin
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
                r_removed    <= '0;
            end else if (r_state == S_SCAN && r_chk_vld) begin
                unique case (r_in.kind)
                    KIND_CLASSIFY, KIND_KEEP: begin
                        if (r_valid[r_chk_idx] && r_rd.track == r_in.track_id && !r_found) begin
                            r_found <= 1'b1;
                            r_slot  <= r_chk_idx;
                            r_match <= r_rd;
                        end
                        if (!r_valid[r_chk_idx] && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free       <= r_chk_idx;
                        end
                    end
                    KIND_PRUNE: begin
                        if (r_valid[r_chk_idx] &&
                            tdiff(r_in.now_ms, r_rd.last_seen) > $signed({9'b0, r_cfg_stale})) begin
                            r_valid[r_chk_idx] <= 1'b0;
                            r_keep[r_chk_idx]  <= 1'b0;
                            if (r_removed != 7'd127) r_removed <= r_removed + 7'd1;
                        end
                    end
                    KIND_SWEEP: begin
                        if (r_valid[r_chk_idx] && !r_keep[r_chk_idx]) begin
                            r_valid[r_chk_idx] <= 1'b0;
                            if (r_removed != 7'd127) r_removed <= r_removed + 7'd1;
                        end
                        r_keep[r_chk_idx] <= 1'b0;
                    end
                    default: begin end
                endcase
            end else if (r_state == S_APPLY && w_out_free) begin
                if (r_in.kind == KIND_KEEP && r_found) begin
                    r_keep[r_slot] <= 1'b1;
                end
                if (w_mem_we && !r_found) begin
                    r_valid[r_cur_slot] <= 1'b1;
                    r_keep[r_cur_slot]  <= 1'b0;
                end
            end
        end
    end

    // pick the entry and square the ranges
    always_comb begin
        w_new_ent            = '0;
        w_new_ent.track      = r_in.track_id;
        w_new_ent.esc        = ESC_UNKNOWN;
        w_new_ent.first_seen = r_in.now_ms;
        w_new_ent.last_seen  = r_in.now_ms;
    end

    assign w_px_sq  = 48'(r_in.pos_x_cm) * 48'(r_in.pos_x_cm);
    assign w_py_sq  = 48'(r_in.pos_y_cm) * 48'(r_in.pos_y_cm);
    assign w_lim_sq = 46'(r_cfg_range) * 46'(r_cfg_range);

    always_ff @(posedge i_clk) begin
        if (r_state == S_CALC) begin
            r_cur      <= r_found ? r_match : w_new_ent;
            r_cur_slot <= r_found ? r_slot : r_free;
            r_full     <= !r_found && !r_free_found;
            r_px2      <= w_px_sq[46:0];
            r_py2      <= w_py_sq[46:0];
            r_lim2     <= w_lim_sq;
        end
    end

    assign w_rule_cfg.threat_speed = r_cfg_speed;
    assign w_rule_cfg.dwell_limit  = r_cfg_dwell;

    ptte_rules u_rules (
        .i_in       (r_in),
        .i_ent      (r_cur),
        .i_cfg      (w_rule_cfg),
        .i_px2      (r_px2),
        .i_py2      (r_py2),
        .i_lim2     (r_lim2),
        .o_ent      (w_upd_ent),
        .o_level    (w_level),
        .o_dwell_ms (w_dwell_ms),
        .o_quality  (w_quality)
    );

    // form the result word
    always_comb begin
        w_word = '0;
        unique case (r_in.kind)
            KIND_CLASSIFY: begin
                w_word.threat_grade = w_level;
                if (r_full) begin
                    w_word.table_full = 1'b1;
                end else begin
                    w_word.escalation     = w_upd_ent.esc;
                    w_word.dwell_ms       = w_dwell_ms;
                    w_word.quality_tenths = w_quality;
                end
            end
            KIND_PRUNE, KIND_SWEEP: w_word.removed_count = r_removed;
            default: begin end
        endcase
    end

    // output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == S_APPLY && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_APPLY && w_out_free) begin
            r_out <= w_word;
        end
    end

    `PTTE_ASSERT(a_accept_idle, i_clk, i_rst_n, (i_valid && !o_stall) |=> (r_state == S_SCAN), "accepted word did not start a walk")
    `PTTE_ASSERT(a_result_src, i_clk, i_rst_n, $rose(o_valid) |-> $past(r_state == S_APPLY), "result word appeared outside the update stage")
    `PTTE_ASSERT_NEVER(a_quality_cap, i_clk, i_rst_n, o_valid && o_data.quality_tenths > 4'd10, "quality above ten")
    `PTTE_ASSERT_NEVER(a_full_clean, i_clk, i_rst_n, o_valid && o_data.table_full && o_data.escalation != ESC_UNKNOWN, "full table word carries an escalation")

endmodule
